@@ rtl/modbus_data_model_engine_macros.svh @@
// assertion macros used by the modbus data model checker
`ifndef MODBUS_DATA_MODEL_ENGINE_MACROS_SVH
`define MODBUS_DATA_MODEL_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MDE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mde_pkg.sv @@
// shared types and constants of the modbus data model engine
package mde_pkg;

  localparam int unsigned MaxRespBytes = 64;
  localparam int unsigned MaxRegCnt    = (MaxRespBytes - 1) / 2;
  localparam int unsigned MaxBitCnt    = (MaxRespBytes - 1) * 8;
  localparam int unsigned ItemW        = $clog2(MaxBitCnt + 1);

  typedef enum logic [2:0] {
    OP_READ_REGS      = 3'd0,
    OP_READ_COILS     = 3'd1,
    OP_READ_DISCRETES = 3'd2,
    OP_WRITE_COIL     = 3'd3,
    OP_WRITE_REG      = 3'd4,
    OP_MULTI_COIL     = 3'd5,
    OP_MULTI_REG      = 3'd6,
    OP_SET_DISCRETE   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_DONE  = 2'd1,
    ST_RANGE = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RESULT,
    S_COUNT,
    S_REG_WAIT,
    S_REG_HI,
    S_REG_LO,
    S_BIT_WAIT,
    S_BIT_ACC,
    S_BIT_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PLAN_NONE,
    PLAN_RESULT,
    PLAN_READ
  } plan_t;

  typedef enum logic [2:0] {
    SEL_RESULT,
    SEL_COUNT,
    SEL_HI,
    SEL_LO,
    SEL_BITS
  } sel_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic exec;
    logic emit;
    sel_t sel;
    logic bit_take;
  } cmd_t;

  typedef struct packed {
    plan_t plan;
    logic  out_free;
    logic  clr_last;
    logic  cnt_zero;
    logic  read_bits;
    logic  reg_last;
    logic  bit_flush;
    logic  bit_last;
  } stat_t;

endpackage

@@ rtl/mde_req_if.sv @@
// request channel: one operation per transfer
interface mde_req_if import mde_pkg::*; ();
  logic        valid;
  logic        ready;
  op_t         operation;
  logic [15:0] address;
  logic [15:0] count;
  logic [15:0] write_value;

  modport source (output valid, operation, address, count, write_value, input ready);
  modport sink (input valid, operation, address, count, write_value, output ready);
endinterface

@@ rtl/mde_rsp_if.sv @@
// response channel: one result byte or status per transfer
interface mde_rsp_if import mde_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  status_t    status;
  logic       last;

  modport source (output valid, data_byte, status, last, input ready);
  modport sink (input valid, data_byte, status, last, output ready);
endinterface

@@ rtl/mde_datapath.sv @@
// datapath: request registers, the three stores, read walk and output register
module mde_datapath import mde_pkg::*; #(
  parameter int unsigned HOLDING_COUNT  = 64,
  parameter int unsigned COIL_COUNT     = 64,
  parameter int unsigned DISCRETE_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  op_t         in_operation,
  input  logic [15:0] in_address,
  input  logic [15:0] in_count,
  input  logic [15:0] in_write_value,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_data_byte,
  output status_t     out_status,
  output logic        out_last
);

  localparam int unsigned HoldW  = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
  localparam int unsigned CoilW  = (COIL_COUNT > 1) ? $clog2(COIL_COUNT) : 1;
  localparam int unsigned DiscW  = (DISCRETE_COUNT > 1) ? $clog2(DISCRETE_COUNT) : 1;
  localparam int unsigned ClrA   = (HOLDING_COUNT > COIL_COUNT) ? HOLDING_COUNT : COIL_COUNT;
  localparam int unsigned ClrLen = (ClrA > DISCRETE_COUNT) ? ClrA : DISCRETE_COUNT;
  localparam int unsigned ClrW   = $clog2(ClrLen + 1);
  localparam logic [16:0] HoldSize = 17'(HOLDING_COUNT);
  localparam logic [16:0] CoilSize = 17'(COIL_COUNT);
  localparam logic [16:0] DiscSize = 17'(DISCRETE_COUNT);
  localparam logic [16:0] ClrEnd   = 17'(ClrLen - 1);

  // latched request
  op_t         op;
  logic [15:0] addr;
  logic [15:0] cnt;
  logic [15:0] val;

  // multiple write stream
  logic [15:0] element_index;
  logic        range_failed;

  status_t          res;
  logic [ItemW-1:0] n;
  logic [7:0]       acc;
  logic [2:0]       pos;
  logic [ClrW-1:0]  clr_idx;

  logic [15:0] hold_mem [HOLDING_COUNT];
  logic        coil_mem [COIL_COUNT];
  logic        disc_mem [DISCRETE_COUNT];
  logic [15:0] hold_rd;
  logic        coil_rd;
  logic        disc_rd;

  logic [16:0] span;
  logic [16:0] target;
  logic [16:0] elem_next;
  logic [16:0] rd_pos;
  logic [16:0] bit_round;
  logic        n_last;
  logic        bit_sel;
  logic [7:0]  count_byte;

  plan_t       plan;
  status_t     res_next;
  logic [16:0] size;
  logic        rf_eff;
  logic        hold_wr;
  logic        coil_wr;
  logic        disc_wr;
  logic [15:0] wr_index;

  logic             hold_we;
  logic [HoldW-1:0] hold_wa;
  logic [15:0]      hold_wd;
  logic             coil_we;
  logic [CoilW-1:0] coil_wa;
  logic             coil_wd;
  logic             disc_we;
  logic [DiscW-1:0] disc_wa;
  logic             disc_wd;

  logic [7:0] emit_data;
  status_t    emit_status;
  logic       emit_last;

  assign span      = 17'(addr) + 17'(cnt);
  assign target    = 17'(addr) + 17'(element_index);
  assign elem_next = 17'(element_index) + 17'd1;
  assign rd_pos    = 17'(addr) + 17'(n);
  assign bit_round = 17'(cnt) + 17'd7;
  assign n_last    = (17'(n) + 17'd1) == 17'(cnt);
  assign bit_sel   = (op == OP_READ_COILS) ? coil_rd : disc_rd;
  assign count_byte = (op == OP_READ_REGS) ? {cnt[6:0], 1'b0} : bit_round[10:3];

  // range checks and write decisions of the latched request
  always_comb begin
    plan     = PLAN_RESULT;
    res_next = ST_DONE;
    size     = HoldSize;
    rf_eff   = range_failed;
    hold_wr  = 1'b0;
    coil_wr  = 1'b0;
    disc_wr  = 1'b0;
    wr_index = addr;
    unique case (op)
      OP_READ_REGS: begin
        if (span > HoldSize) res_next = ST_RANGE;
        else if (cnt > 16'(MaxRegCnt)) res_next = ST_LONG;
        else plan = PLAN_READ;
      end
      OP_READ_COILS: begin
        if (span > CoilSize) res_next = ST_RANGE;
        else if (cnt > 16'(MaxBitCnt)) res_next = ST_LONG;
        else plan = PLAN_READ;
      end
      OP_READ_DISCRETES: begin
        if (span > DiscSize) res_next = ST_RANGE;
        else if (cnt > 16'(MaxBitCnt)) res_next = ST_LONG;
        else plan = PLAN_READ;
      end
      OP_WRITE_COIL: begin
        if (17'(addr) >= CoilSize) res_next = ST_RANGE;
        else coil_wr = 1'b1;
      end
      OP_WRITE_REG: begin
        if (17'(addr) >= HoldSize) res_next = ST_RANGE;
        else hold_wr = 1'b1;
      end
      OP_SET_DISCRETE: begin
        if (17'(addr) >= DiscSize) res_next = ST_RANGE;
        else disc_wr = 1'b1;
      end
      OP_MULTI_COIL, OP_MULTI_REG: begin
        size     = (op == OP_MULTI_COIL) ? CoilSize : HoldSize;
        wr_index = target[15:0];
        if (element_index == 16'd0) rf_eff = span > size;
        if (cnt != 16'd0 && !rf_eff && target < size) begin
          if (op == OP_MULTI_COIL) coil_wr = 1'b1;
          else hold_wr = 1'b1;
        end
        if (elem_next >= 17'(cnt)) res_next = rf_eff ? ST_RANGE : ST_DONE;
        else plan = PLAN_NONE;
      end
      default: plan = PLAN_RESULT;
    endcase
  end

  // store write ports: clearing pass or request write
  always_comb begin
    hold_we = 1'b0;
    hold_wa = wr_index[HoldW-1:0];
    hold_wd = val;
    coil_we = 1'b0;
    coil_wa = wr_index[CoilW-1:0];
    coil_wd = val[0];
    disc_we = 1'b0;
    disc_wa = wr_index[DiscW-1:0];
    disc_wd = val[0];
    if (cmd.clr_step) begin
      hold_we = 17'(clr_idx) < HoldSize;
      hold_wa = clr_idx[HoldW-1:0];
      hold_wd = '0;
      coil_we = 17'(clr_idx) < CoilSize;
      coil_wa = clr_idx[CoilW-1:0];
      coil_wd = 1'b0;
      disc_we = 17'(clr_idx) < DiscSize;
      disc_wa = clr_idx[DiscW-1:0];
      disc_wd = 1'b0;
    end else if (cmd.exec) begin
      hold_we = hold_wr;
      coil_we = coil_wr;
      disc_we = disc_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_we) hold_mem[hold_wa] <= hold_wd;
    hold_rd <= hold_mem[rd_pos[HoldW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (coil_we) coil_mem[coil_wa] <= coil_wd;
    coil_rd <= coil_mem[rd_pos[CoilW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (disc_we) disc_mem[disc_wa] <= disc_wd;
    disc_rd <= disc_mem[rd_pos[DiscW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= in_operation;
      addr <= in_address;
      cnt  <= in_count;
      val  <= in_write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_index <= '0;
      range_failed  <= 1'b0;
    end else if (cmd.exec) begin
      if (plan == PLAN_NONE) begin
        element_index <= elem_next[15:0];
        range_failed  <= rf_eff;
      end else begin
        element_index <= '0;
        range_failed  <= 1'b0;
      end
    end
  end

  // read walk
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res <= res_next;
      n   <= '0;
      acc <= '0;
      pos <= '0;
    end else if (cmd.bit_take) begin
      acc[pos] <= bit_sel;
      pos      <= pos + 3'd1;
      n        <= n + 1'b1;
    end else if (cmd.emit && cmd.sel == SEL_BITS) begin
      acc <= '0;
      pos <= '0;
    end else if (cmd.emit && cmd.sel == SEL_LO) begin
      n <= n + 1'b1;
    end
  end

  always_comb begin
    emit_data   = '0;
    emit_status = ST_DATA;
    emit_last   = 1'b0;
    unique case (cmd.sel)
      SEL_RESULT: begin
        emit_status = res;
        emit_last   = 1'b1;
      end
      SEL_COUNT: begin
        emit_data = count_byte;
        emit_last = cnt == 16'd0;
      end
      SEL_HI:   emit_data = hold_rd[15:8];
      SEL_LO: begin
        emit_data = hold_rd[7:0];
        emit_last = n_last;
      end
      SEL_BITS: begin
        emit_data = acc;
        emit_last = 16'(n) == cnt;
      end
      default: emit_data = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_byte <= emit_data;
      out_status    <= emit_status;
      out_last      <= emit_last;
    end
  end

  assign st.plan      = plan;
  assign st.out_free  = !out_valid || out_ready;
  assign st.clr_last  = 17'(clr_idx) == ClrEnd;
  assign st.cnt_zero  = cnt == 16'd0;
  assign st.read_bits = op != OP_READ_REGS;
  assign st.reg_last  = n_last;
  assign st.bit_flush = (pos == 3'd7) || n_last;
  assign st.bit_last  = 16'(n) == cnt;

endmodule

@@ rtl/mde_ctrl.sv @@
// controller state machine sequencing clear, decode, writes and read responses
module mde_ctrl import mde_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (st.clr_last) state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (st.plan)
          PLAN_RESULT: state_next = S_RESULT;
          PLAN_READ:   state_next = S_COUNT;
          default:     state_next = S_IDLE;
        endcase
      end
      S_RESULT: if (st.out_free) state_next = S_IDLE;
      S_COUNT: begin
        if (st.out_free) begin
          if (st.cnt_zero) state_next = S_IDLE;
          else if (st.read_bits) state_next = S_BIT_WAIT;
          else state_next = S_REG_WAIT;
        end
      end
      S_REG_WAIT: state_next = S_REG_HI;
      S_REG_HI: if (st.out_free) state_next = S_REG_LO;
      S_REG_LO: begin
        if (st.out_free) state_next = st.reg_last ? S_IDLE : S_REG_WAIT;
      end
      S_BIT_WAIT: state_next = S_BIT_ACC;
      S_BIT_ACC: state_next = st.bit_flush ? S_BIT_EMIT : S_BIT_WAIT;
      S_BIT_EMIT: begin
        if (st.out_free) state_next = st.bit_last ? S_IDLE : S_BIT_WAIT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.clr_step = 1'b0;
    cmd.exec     = 1'b0;
    cmd.emit     = 1'b0;
    cmd.sel      = SEL_RESULT;
    cmd.bit_take = 1'b0;
    unique case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: cmd.exec = 1'b1;
      S_RESULT: cmd.emit = st.out_free;
      S_COUNT: begin
        cmd.emit = st.out_free;
        cmd.sel  = SEL_COUNT;
      end
      S_REG_HI: begin
        cmd.emit = st.out_free;
        cmd.sel  = SEL_HI;
      end
      S_REG_LO: begin
        cmd.emit = st.out_free;
        cmd.sel  = SEL_LO;
      end
      S_BIT_ACC: cmd.bit_take = 1'b1;
      S_BIT_EMIT: begin
        cmd.emit = st.out_free;
        cmd.sel  = SEL_BITS;
      end
      default: cmd.sel = SEL_RESULT;
    endcase
  end

endmodule

@@ rtl/modbus_data_model_engine.sv @@
// modbus slave data model: holding registers, coils and discrete inputs
// requests: a transfer latches the request, S_DECODE decodes it, and S_RESULT or S_COUNT
//   registers the first result; a multiple write element other than the last gives none
// register reads: byte count, then per register one store read and two bytes
// coil/discrete reads: byte count, then read and accumulate per bit, emit per packed byte
// reset: synchronous; the stores are zeroed one entry a cycle, up to
//   max(HOLDING_COUNT, COIL_COUNT, DISCRETE_COUNT) entries, with req.ready low meanwhile
module modbus_data_model_engine import mde_pkg::*; #(
  parameter int unsigned HOLDING_COUNT  = 64,
  parameter int unsigned COIL_COUNT     = 64,
  parameter int unsigned DISCRETE_COUNT = 64
) (
  input logic        clk,
  input logic        rst,
  mde_req_if.sink    req,
  mde_rsp_if.source  rsp
);

  cmd_t  cmd;
  stat_t st;

  mde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  mde_datapath #(
    .HOLDING_COUNT  (HOLDING_COUNT),
    .COIL_COUNT     (COIL_COUNT),
    .DISCRETE_COUNT (DISCRETE_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .in_operation   (req.operation),
    .in_address     (req.address),
    .in_count       (req.count),
    .in_write_value (req.write_value),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .out_data_byte  (rsp.data_byte),
    .out_status     (rsp.status),
    .out_last       (rsp.last)
  );

endmodule

@@ rtl/mde_checker.sv @@
// port-level checker for the modbus data model engine, bound to the top level
`include "modbus_data_model_engine_macros.svh"

module mde_checker import mde_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_data_byte,
  input status_t    rsp_status,
  input logic       rsp_last
);

  `MDE_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after transfer")
  `MDE_ASSERT_IMPL(a_busy_mid_response, rsp_valid && !rsp_last, !req_ready, "ready mid response")
  `MDE_ASSERT_IMPL(a_flag_form, rsp_valid && rsp_status != ST_DATA, rsp_data_byte == 8'd0 && rsp_last, "bad flag result")
  `MDE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_byte) && $stable(rsp_status) && $stable(rsp_last), "stalled result changed")

endmodule

bind modbus_data_model_engine mde_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_data_byte (rsp.data_byte),
  .rsp_status    (rsp.status),
  .rsp_last      (rsp.last)
);
